// File: rtl/urhr_pkg.sv
// Shared opcodes and fixed widths for the undo/redo history ring.
`default_nettype none

package urhr_pkg;

	localparam int OP_W = 2;
	localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
	localparam logic [OP_W-1:0] OP_UNDO  = 2'd1;
	localparam logic [OP_W-1:0] OP_REDO  = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

	localparam int BUDGET_W = 30;
	localparam logic [BUDGET_W-1:0] BUDGET_RESET = '1;

endpackage

`default_nettype wire

// File: rtl/urhr_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module urhr_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: rtl/undo_redo_history_ring.sv
// Top level of the undo/redo history ring: sequencer, status registers and entry RAM.
`default_nettype none

// Undo/redo history ring. Entries (handle and byte size) live in one RAM addressed as a
// ring from the oldest slot; a cursor splits undo entries from redo entries and a running
// byte total is kept against the memory_budget register. One word is taken at a time and
// gives exactly one result word. Undo, redo, clear and a push without changes go
// straight to the finish state, which a stalled output holds. A push with changes
// drops the redo entries, evicts the oldest entry on a full ring, appends, and
// evicts oldest entries while over budget, reading each size through the registered
// RAM read port. memory_budget may be written only while the block is idle.
module undo_redo_history_ring #(
	parameter int DEPTH       = 64,
	parameter int HANDLE_BITS = 16,
	parameter int SIZE_BITS   = 24,
	localparam int CNT_W      = $clog2(DEPTH + 1)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration
	input  wire logic                              cfg_we,
	input  wire logic [urhr_pkg::BUDGET_W-1:0]     cfg_wdata,
	// input channel
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [urhr_pkg::OP_W-1:0]         opcode,
	input  wire logic [HANDLE_BITS-1:0]            entry_handle,
	input  wire logic [SIZE_BITS-1:0]              entry_bytes,
	input  wire logic                              has_changes,
	// output channel
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [HANDLE_BITS-1:0]            handle_out,
	output logic                                   handle_valid,
	output logic                                   can_undo,
	output logic                                   can_redo,
	output logic      [CNT_W-1:0]                  entries_held,
	output logic      [CNT_W-1:0]                  undo_position,
	output logic      [urhr_pkg::BUDGET_W-1:0]     memory_used,
	output logic      [CNT_W-1:0]                  evicted_count
);

	import urhr_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SUM_W = ((SIZE_BITS > BUDGET_W) ? SIZE_BITS : BUDGET_W) + 1;
	localparam int RAM_W = HANDLE_BITS + SIZE_BITS;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DROP_RD  = 4'd1;
	localparam logic [3:0] S_DROP_SUB = 4'd2;
	localparam logic [3:0] S_FULL_RD  = 4'd3;
	localparam logic [3:0] S_FULL_SUB = 4'd4;
	localparam logic [3:0] S_APPEND   = 4'd5;
	localparam logic [3:0] S_BUD_RD   = 4'd6;
	localparam logic [3:0] S_BUD_SUB  = 4'd7;
	localparam logic [3:0] S_FINISH   = 4'd8;

	logic [3:0]             state_q;
	logic [CNT_W-1:0]       held_q;
	logic [CNT_W-1:0]       cursor_q;
	logic [IDX_W-1:0]       oldest_q;
	logic [SUM_W-1:0]       total_q;
	logic [BUDGET_W-1:0]    budget_q;
	logic [CNT_W-1:0]       evicted_q;
	logic                   hv_pend_q;
	logic [HANDLE_BITS-1:0] push_handle_q;
	logic [SIZE_BITS-1:0]   push_size_q;

	logic                   out_valid_q;
	logic [HANDLE_BITS-1:0] handle_out_q;
	logic                   handle_valid_q;
	logic [CNT_W-1:0]       held_out_q;
	logic [CNT_W-1:0]       cursor_out_q;
	logic [BUDGET_W-1:0]    used_out_q;
	logic [CNT_W-1:0]       evicted_out_q;

	logic                   in_fire;
	logic                   rd_en;
	logic [CNT_W-1:0]       rd_pos;
	logic                   wr_en;
	logic [IDX_W-1:0]       raddr;
	logic [IDX_W-1:0]       waddr;
	logic [RAM_W-1:0]       rdata;
	logic [SIZE_BITS-1:0]   rd_size;
	logic [HANDLE_BITS-1:0] rd_handle;
	logic                   over_budget;
	logic                   out_free;
	logic [IDX_W-1:0]       oldest_next;

	// Ring position to RAM slot: both operands are below DEPTH plus one, so one
	// conditional subtract wraps the sum.
	function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] oldest,
			input logic [CNT_W-1:0] pos);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(oldest) + (CNT_W+1)'(pos);
		if (s >= (CNT_W+1)'(DEPTH)) begin
			s = s - (CNT_W+1)'(DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

	assign in_stall    = (state_q != S_IDLE);
	assign in_fire     = in_valid && !in_stall;
	assign out_free    = !out_valid_q || !out_stall;
	assign rd_size     = rdata[SIZE_BITS-1:0];
	assign rd_handle   = rdata[RAM_W-1:SIZE_BITS];
	assign over_budget = (total_q > SUM_W'(budget_q)) && (held_q != '0);
	assign oldest_next = (oldest_q == IDX_W'(DEPTH - 1)) ? '0 : oldest_q + IDX_W'(1);

	always_comb begin
		rd_en  = 1'b0;
		rd_pos = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && opcode == OP_UNDO && cursor_q != '0) begin
					rd_en  = 1'b1;
					rd_pos = cursor_q - CNT_W'(1);
				end else if (in_fire && opcode == OP_REDO && cursor_q < held_q) begin
					rd_en  = 1'b1;
					rd_pos = cursor_q;
				end
			end
			S_DROP_RD: begin
				if (held_q > cursor_q) begin
					rd_en  = 1'b1;
					rd_pos = held_q - CNT_W'(1);
				end
			end
			S_FULL_RD: begin
				rd_en = 1'b1;
			end
			S_BUD_RD: begin
				rd_en = over_budget;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	assign wr_en = (state_q == S_APPEND);
	assign raddr = slot_of(oldest_q, rd_pos);
	assign waddr = slot_of(oldest_q, held_q);

	urhr_ram #(
		.WIDTH (RAM_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr),
		.wdata ({push_handle_q, push_size_q}),
		.re    (rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= BUDGET_RESET;
		end else if (cfg_we) begin
			budget_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			push_handle_q <= entry_handle;
			push_size_q   <= entry_bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			held_q    <= '0;
			cursor_q  <= '0;
			oldest_q  <= '0;
			total_q   <= '0;
			evicted_q <= '0;
			hv_pend_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						evicted_q <= '0;
						hv_pend_q <= 1'b0;
						state_q   <= S_FINISH;
						unique case (opcode)
							OP_PUSH: begin
								if (has_changes) begin
									state_q <= S_DROP_RD;
								end
							end
							OP_UNDO: begin
								if (cursor_q != '0) begin
									cursor_q  <= cursor_q - CNT_W'(1);
									hv_pend_q <= 1'b1;
								end
							end
							OP_REDO: begin
								if (cursor_q < held_q) begin
									cursor_q  <= cursor_q + CNT_W'(1);
									hv_pend_q <= 1'b1;
								end
							end
							OP_CLEAR: begin
								held_q   <= '0;
								cursor_q <= '0;
								oldest_q <= '0;
								total_q  <= '0;
							end
						endcase
					end
				end
				S_DROP_RD: begin
					if (held_q > cursor_q) begin
						held_q  <= held_q - CNT_W'(1);
						state_q <= S_DROP_SUB;
					end else if (held_q == CNT_W'(DEPTH)) begin
						state_q <= S_FULL_RD;
					end else begin
						state_q <= S_APPEND;
					end
				end
				S_DROP_SUB: begin
					total_q <= total_q - SUM_W'(rd_size);
					state_q <= S_DROP_RD;
				end
				S_FULL_RD: begin
					state_q <= S_FULL_SUB;
				end
				S_FULL_SUB: begin
					total_q   <= total_q - SUM_W'(rd_size);
					oldest_q  <= oldest_next;
					held_q    <= held_q - CNT_W'(1);
					cursor_q  <= (cursor_q != '0) ? cursor_q - CNT_W'(1) : cursor_q;
					evicted_q <= evicted_q + CNT_W'(1);
					state_q   <= S_APPEND;
				end
				S_APPEND: begin
					held_q   <= held_q + CNT_W'(1);
					cursor_q <= held_q + CNT_W'(1);
					total_q  <= total_q + SUM_W'(push_size_q);
					state_q  <= S_BUD_RD;
				end
				S_BUD_RD: begin
					state_q <= over_budget ? S_BUD_SUB : S_FINISH;
				end
				S_BUD_SUB: begin
					total_q   <= total_q - SUM_W'(rd_size);
					oldest_q  <= oldest_next;
					held_q    <= held_q - CNT_W'(1);
					cursor_q  <= (cursor_q != '0) ? cursor_q - CNT_W'(1) : cursor_q;
					evicted_q <= evicted_q + CNT_W'(1);
					state_q   <= S_BUD_RD;
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The RAM read data holds its value until the next read, so the handle of an
	// undo or redo is still there when the result word is loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && out_free) begin
			handle_out_q   <= hv_pend_q ? rd_handle : '0;
			handle_valid_q <= hv_pend_q;
			held_out_q     <= held_q;
			cursor_out_q   <= cursor_q;
			used_out_q     <= total_q[BUDGET_W-1:0];
			evicted_out_q  <= evicted_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign handle_out    = handle_out_q;
	assign handle_valid  = handle_valid_q;
	assign can_undo      = (cursor_out_q != '0);
	assign can_redo      = (cursor_out_q < held_out_q);
	assign entries_held  = held_out_q;
	assign undo_position = cursor_out_q;
	assign memory_used   = used_out_q;
	assign evicted_count = evicted_out_q;

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= held_q && held_q <= CNT_W'(DEPTH))
		else $error("cursor or entry count out of range");

	a_total_settled: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> total_q <= SUM_W'(BUDGET_RESET))
		else $error("byte total exceeds register range between words");

	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FINISH && out_free |=> out_valid_q && state_q == S_IDLE)
		else $error("result word not loaded on finish");

	a_no_handle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !handle_valid_q |-> handle_out_q == '0)
		else $error("handle driven without a returned entry");

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the undo/redo history ring with a scoreboard class and driver tasks.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import urhr_pkg::*;

	localparam int RING_DEPTH = 64;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [15:0]     handle;
		logic [23:0]     size;
		logic            changes;
	} command_t;

	typedef struct packed {
		logic [15:0]         handle;
		logic                handle_ok;
		logic                can_undo;
		logic                can_redo;
		logic [6:0]          held;
		logic [6:0]          position;
		logic [BUDGET_W-1:0] used;
		logic [6:0]          evicted;
	} status_t;

	// Tracks the ring contents, predicts the status word of each command and checks it.
	class history_checker;
		bit [15:0]           handle_mem[RING_DEPTH];
		bit [23:0]           size_mem[RING_DEPTH];
		int unsigned         oldest;
		int unsigned         held;
		int unsigned         cursor_pos;
		longint unsigned     bytes;
		bit [BUDGET_W-1:0]   budget;
		status_t             expected_status[$];
		int unsigned         failures;
		int unsigned         results_seen;
		int unsigned         handles_returned;
		int unsigned         evictions;
		int unsigned         full_ring_pushes;
		int unsigned         peak_held;

		function new();
			oldest = 0;
			held = 0;
			cursor_pos = 0;
			bytes = 0;
			budget = BUDGET_RESET;
			failures = 0;
			results_seen = 0;
			handles_returned = 0;
			evictions = 0;
			full_ring_pushes = 0;
			peak_held = 0;
		endfunction

		function void retire_oldest();
			bytes -= size_mem[oldest];
			oldest = (oldest + 1) % RING_DEPTH;
			held--;
			if (cursor_pos > 0) begin
				cursor_pos--;
			end
		endfunction

		function void note_command(command_t c);
			status_t     s;
			int unsigned slot;
			int unsigned ev;
			s = '0;
			ev = 0;
			case (c.op)
				OP_PUSH: begin
					if (c.changes) begin
						// Redo entries past the cursor are dropped without counting as evictions.
						while (held > cursor_pos) begin
							held--;
							bytes -= size_mem[(oldest + held) % RING_DEPTH];
						end
						if (held >= RING_DEPTH) begin
							full_ring_pushes++;
							retire_oldest();
							ev++;
						end
						slot = (oldest + held) % RING_DEPTH;
						handle_mem[slot] = c.handle;
						size_mem[slot] = c.size;
						held++;
						bytes += c.size;
						cursor_pos = held;
						while (bytes > budget && held > 0) begin
							retire_oldest();
							ev++;
						end
					end
				end
				OP_UNDO: begin
					if (cursor_pos > 0) begin
						cursor_pos--;
						s.handle = handle_mem[(oldest + cursor_pos) % RING_DEPTH];
						s.handle_ok = 1'b1;
					end
				end
				OP_REDO: begin
					if (cursor_pos < held) begin
						s.handle = handle_mem[(oldest + cursor_pos) % RING_DEPTH];
						s.handle_ok = 1'b1;
						cursor_pos++;
					end
				end
				default: begin
					held = 0;
					cursor_pos = 0;
					bytes = 0;
					oldest = 0;
				end
			endcase
			s.can_undo = (cursor_pos > 0);
			s.can_redo = (cursor_pos < held);
			s.held = 7'(held);
			s.position = 7'(cursor_pos);
			s.used = bytes[BUDGET_W-1:0];
			s.evicted = 7'(ev);
			evictions += ev;
			if (s.handle_ok) begin
				handles_returned++;
			end
			if (held > peak_held) begin
				peak_held = held;
			end
			expected_status = {expected_status, s};
		endfunction

		function void compare(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				failures++;
			end
		endfunction

		function void check_status(status_t got);
			status_t want;
			results_seen++;
			if (expected_status.size() == 0) begin
				$error("status word arrived with no command outstanding");
				failures++;
				return;
			end
			want = expected_status[0];
			expected_status.delete(0);
			compare("handle_out", 32'(want.handle), 32'(got.handle));
			compare("handle_valid", 32'(want.handle_ok), 32'(got.handle_ok));
			compare("can_undo", 32'(want.can_undo), 32'(got.can_undo));
			compare("can_redo", 32'(want.can_redo), 32'(got.can_redo));
			compare("entries_held", 32'(want.held), 32'(got.held));
			compare("undo_position", 32'(want.position), 32'(got.position));
			compare("memory_used", 32'(want.used), 32'(got.used));
			compare("evicted_count", 32'(want.evicted), 32'(got.evicted));
		endfunction
	endclass

	logic                clk;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [BUDGET_W-1:0] cfg_wdata = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [OP_W-1:0]     opcode = OP_PUSH;
	logic [15:0]         entry_handle = '0;
	logic [23:0]         entry_bytes = '0;
	logic                has_changes = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [15:0]         handle_out;
	logic                handle_valid;
	logic                can_undo;
	logic                can_redo;
	logic [6:0]          entries_held;
	logic [6:0]          undo_position;
	logic [BUDGET_W-1:0] memory_used;
	logic [6:0]          evicted_count;

	history_checker board = new();
	int unsigned    words_sent = 0;
	int unsigned    budgets_used = 1;

	undo_redo_history_ring i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.entry_handle (entry_handle),
		.entry_bytes  (entry_bytes),
		.has_changes  (has_changes),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.handle_out   (handle_out),
		.handle_valid (handle_valid),
		.can_undo     (can_undo),
		.can_redo     (can_redo),
		.entries_held (entries_held),
		.undo_position(undo_position),
		.memory_used  (memory_used),
		.evicted_count(evicted_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#10000000;
		$display("*** FAILED ***");
		$finish;
	end

	// Called at a rising edge; returns at the edge where the word was taken.
	task automatic send_word(input logic [OP_W-1:0] op, input logic [15:0] h,
			input logic [23:0] sz, input logic chg);
		command_t    c;
		int unsigned gap;
		gap = 0;
		if (!(words_sent >= 1000 && words_sent < 1300) && $urandom_range(99) < 9) begin
			gap = $urandom_range(1, 4);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		entry_handle <= h;
		entry_bytes <= sz;
		has_changes <= chg;
		do @(posedge clk); while (in_stall);
		c.op = op;
		c.handle = h;
		c.size = sz;
		c.changes = chg;
		board.note_command(c);
		words_sent++;
	endtask

	task automatic set_budget(input logic [BUDGET_W-1:0] value);
		in_valid <= 1'b0;
		while (board.expected_status.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.budget = value;
		budgets_used++;
	endtask

	task automatic random_word(input int unsigned size_cap, input int unsigned clear_pm);
		int unsigned     r;
		int unsigned     rs;
		logic [OP_W-1:0] op;
		logic [15:0]     h;
		logic [23:0]     sz;
		logic            chg;
		r = $urandom_range(999);
		op = OP_PUSH;
		chg = 1'b1;
		if (r < clear_pm) begin
			op = OP_CLEAR;
		end else if (r < 200 + clear_pm) begin
			op = OP_UNDO;
		end else if (r < 400 + clear_pm) begin
			op = OP_REDO;
		end else if (r < 430 + clear_pm) begin
			chg = 1'b0;
		end
		if (op != OP_PUSH) begin
			chg = 1'($urandom_range(1));
		end
		rs = $urandom_range(99);
		if (rs < 5) begin
			sz = '0;
		end else if (rs < 10) begin
			sz = '1;
		end else if (rs < 30) begin
			sz = 24'($urandom);
		end else begin
			sz = 24'($urandom_range(size_cap, 0));
		end
		rs = $urandom_range(19);
		if (rs == 0) begin
			h = '0;
		end else if (rs == 1) begin
			h = '1;
		end else begin
			h = 16'($urandom);
		end
		send_word(op, h, sz, chg);
	endtask

	task automatic run_phase(input int unsigned count, input int unsigned size_cap,
			input int unsigned clear_pm);
		repeat (count) random_word(size_cap, clear_pm);
	endtask

	// Output side: random stalls, one long hold to back the block up, and a quiet stretch.
	initial begin
		int unsigned hold_left;
		bit          pressed;
		hold_left = 0;
		pressed = 0;
		forever begin
			@(posedge clk);
			if (!pressed && board.results_seen >= 700) begin
				pressed = 1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (board.results_seen >= 1000 && board.results_seen < 1300) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < 9);
			end
		end
	end

	always @(posedge clk) begin : watch_status
		status_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.handle = handle_out;
			got.handle_ok = handle_valid;
			got.can_undo = can_undo;
			got.can_redo = can_redo;
			got.held = entries_held;
			got.position = undo_position;
			got.used = memory_used;
			got.evicted = evicted_count;
			board.check_status(got);
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Boundaries on an empty ring, field extremes, a push without changes, redo truncation.
		send_word(OP_UNDO, 16'h0000, 24'h000000, 1'b0);
		send_word(OP_REDO, 16'hFFFF, 24'hFFFFFF, 1'b1);
		send_word(OP_PUSH, 16'h0000, 24'h000000, 1'b1);
		send_word(OP_PUSH, 16'hFFFF, 24'hFFFFFF, 1'b1);
		send_word(OP_PUSH, 16'hFFFF, 24'hFFFFFF, 1'b0);
		send_word(OP_PUSH, 16'h1234, 24'h00ABCD, 1'b1);
		send_word(OP_UNDO, 16'h0000, 24'h000000, 1'b0);
		send_word(OP_UNDO, 16'hFFFF, 24'hFFFFFF, 1'b1);
		send_word(OP_UNDO, 16'h0000, 24'h000000, 1'b0);
		send_word(OP_UNDO, 16'h0000, 24'h000000, 1'b0);
		send_word(OP_REDO, 16'h0000, 24'h000000, 1'b0);
		send_word(OP_REDO, 16'h0000, 24'h000000, 1'b0);
		send_word(OP_REDO, 16'h0000, 24'h000000, 1'b0);
		send_word(OP_REDO, 16'h0000, 24'h000000, 1'b0);
		send_word(OP_UNDO, 16'h0000, 24'h000000, 1'b0);
		send_word(OP_UNDO, 16'h0000, 24'h000000, 1'b0);
		send_word(OP_PUSH, 16'h5A5A, 24'hA5A5A5, 1'b1);
		send_word(OP_REDO, 16'h0000, 24'h000000, 1'b0);
		send_word(OP_CLEAR, 16'hFFFF, 24'hFFFFFF, 1'b1);
		send_word(OP_UNDO, 16'h0000, 24'h000000, 1'b0);
		send_word(OP_REDO, 16'h0000, 24'h000000, 1'b0);
		send_word(OP_CLEAR, 16'h0000, 24'h000000, 1'b0);
		send_word(OP_PUSH, 16'hA5A5, 24'h5A5A5A, 1'b1);

		// Budgets change with entries still held, so the first push of a phase may evict many.
		run_phase(450, 1 << 20, 3);
		set_budget('0);
		run_phase(150, 0, 10);
		set_budget(30'd20_000_000);
		run_phase(250, 4_000_000, 10);
		set_budget('1);
		run_phase(450, 24'hFFFFFF, 2);
		set_budget(30'($urandom_range(30'h1FFFFFFF, 1)));
		run_phase(300, 1 << 22, 8);
		set_budget(30'd1);
		run_phase(100, 2, 10);
		set_budget(30'd300_000_000);
		run_phase(230, 1 << 23, 5);

		in_valid <= 1'b0;
		while (board.expected_status.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d words under %0d budget settings; %0d status words checked.",
			words_sent, budgets_used, board.results_seen);
		$display("Undo/redo returned %0d handles, %0d entries evicted (%0d on a full ring),",
			board.handles_returned, board.evictions, board.full_ring_pushes);
		$display("and the ring held at most %0d entries.", board.peak_held);
		if (board.failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

`default_nettype wire
